/* design/vn_pkg.sv */
// Shared widths and sideband types for the vector normalize pipeline.
package vn_pkg;

  // Field width of every component, the target and the norm
  localparam int unsigned DW = 24;
  // Width of squares, products and their sums
  localparam int unsigned SW = 2 * DW;
  // One root bit per stage, one quotient bit per stage
  localparam int unsigned ROOT_STAGES = DW;
  localparam int unsigned DIV_STAGES  = DW;
  // Largest positive value of a signed field
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};

  // Words that ride beside the square root
  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][SW-1:0] prod;
  } vn_side_a_t;

  // Words that ride beside the dividers
  typedef struct packed {
    logic [2:0]    neg;
    logic [DW-1:0] norm;
  } vn_side_b_t;

endpackage

/* design/vn_sqrt.sv */
// Pipelined integer square root, one root bit resolved per stage.
module vn_sqrt
  import vn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] rad_i,
  output logic          valid_o,
  output logic [DW-1:0] root_o
);

  logic [SW-1:0] rad_q  [ROOT_STAGES];
  logic [DW+1:0] rem_q  [ROOT_STAGES];
  logic [DW-1:0] root_q [ROOT_STAGES];
  logic          v_q    [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stg
    logic [SW-1:0] rad_in;
    logic [DW+1:0] rem_in;
    logic [DW-1:0] root_in;
    logic          v_in;
    logic [DW+1:0] cur;
    logic [DW+1:0] trial;
    logic          ge;

    // Select the stage input
    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {rem_in[DW-1:0], rad_in[SW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    // Hold valid under stall
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // Advance the partial root and remainder
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (cur - trial) : cur;
        root_q[k] <= {root_in[DW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[ROOT_STAGES-1];
  assign root_o  = root_q[ROOT_STAGES-1];

endmodule

/* design/vn_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module vn_div
  import vn_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [DW-1:0] quot_o
);

  // The quotient always fits DW bits, so the top half starts as the remainder
  logic [DW-1:0] rem_q  [DIV_STAGES];
  logic [DW-1:0] low_q  [DIV_STAGES];
  logic [DW-1:0] dv_q   [DIV_STAGES];
  logic [DW-1:0] quot_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [DW-1:0] low_in;
    logic [DW-1:0] dv_in;
    logic [DW-1:0] quot_in;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;

    // Select the stage input
    if (k == 0) begin : g_first
      assign rem_in  = dividend_i[SW-1:DW];
      assign low_in  = dividend_i[DW-1:0];
      assign dv_in   = divisor_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign dv_in   = dv_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    // Shift in one dividend bit and compare against the divisor
    assign cur  = {rem_in, low_in[DW-1]};
    assign diff = cur - {1'b0, dv_in};
    assign ge   = (cur >= {1'b0, dv_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
        low_q[k]  <= low_in << 1;
        dv_q[k]   <= dv_in;
        quot_q[k] <= {quot_in[DW-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[DIV_STAGES-1];

endmodule

/* design/vector3_normalize_to_length.sv */
// Top level: scale a 3-D vector to a target length, fully pipelined.
//
//  channel  dir  payload                                      handshake
//  s_axis   in   tdata: in_x, in_y, in_z, target_length       tvalid/tready
//  m_axis   out  tdata: out_x, out_y, out_z, length;          tvalid/tready
//                tuser: saturated
//
// One word enters per cycle while m_axis is not stalled; the pipe holds three front stages
// (magnitude, multiply, sum), 24 square-root stages, one rounding stage,
// 24 divider stages and the output register.
// Reset clears only the valid bits. A stall at m_axis freezes every stage
// at once, so nothing is lost or repeated; s_axis_tready follows it.
module vector3_normalize_to_length
  import vn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // in_x [23:0], in_y [47:24], in_z [71:48], target_length [95:72]
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_x [23:0], out_y [47:24], out_z [71:48], length [95:72]
  output logic [95:0]   m_axis_tdata,
  // saturated [0]
  output logic [0:0]    m_axis_tuser
);

  logic en;
  logic out_v_q;

  // Advance the whole pipe when the output register is free
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: magnitudes and signs
  logic [2:0][DW-1:0] mag1_q;
  logic [2:0]         sgn1_q;
  logic [DW-1:0]      tmag1_q;
  logic               tsgn1_q;
  logic               v1_q;
  logic [3:0][DW-1:0] in_f;

  assign in_f = s_axis_tdata;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= in_f[i][DW-1] ? (~in_f[i] + 1'b1) : in_f[i];
        sgn1_q[i] <= in_f[i][DW-1];
      end
      tmag1_q <= in_f[3][DW-1] ? (~in_f[3] + 1'b1) : in_f[3];
      tsgn1_q <= in_f[3][DW-1];
    end
  end

  // Stage 2: squares and products with the target
  logic [2:0][SW-1:0] sq2_q;
  vn_side_a_t         side2_q;
  logic               v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i]        <= SW'(mag1_q[i]) * SW'(mag1_q[i]);
        side2_q.prod[i] <= SW'(mag1_q[i]) * SW'(tmag1_q);
        side2_q.neg[i]  <= sgn1_q[i] ^ tsgn1_q;
      end
    end
  end

  // Stage 3: sum of squares
  logic [SW-1:0] sum3_q;
  vn_side_a_t    side3_q;
  logic          v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      side3_q <= side2_q;
    end
  end

  // Front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Square root
  logic          vr;
  logic [DW-1:0] norm;

  vn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .valid_o (vr),
    .root_o  (norm)
  );

  // Delay products and signs alongside the root
  vn_side_a_t side_a_q [ROOT_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q[0] <= side3_q;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        side_a_q[k] <= side_a_q[k-1];
      end
    end
  end

  // Stage 4: add half the norm for round to nearest
  logic [2:0][SW-1:0] dvd4_q;
  vn_side_b_t         side4_q;
  logic               v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dvd4_q[i] <= side_a_q[ROOT_STAGES-1].prod[i] + SW'(norm >> 1);
      end
      side4_q.neg  <= side_a_q[ROOT_STAGES-1].neg;
      side4_q.norm <= norm;
    end
  end

  // Dividers, one per component
  logic [2:0][DW-1:0] quot;

  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk_i      (clk_i),
      .en_i       (en),
      .dividend_i (dvd4_q[i]),
      .divisor_i  (side4_q.norm),
      .quot_o     (quot[i])
    );
  end

  // Delay norm and signs alongside the quotients
  vn_side_b_t side_b_q [DIV_STAGES];
  logic       vb_q     [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q[0] <= side4_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_b_q[k] <= side_b_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        vb_q[k] <= 1'b0;
      end
    end else if (en) begin
      v4_q    <= vr;
      vb_q[0] <= v4_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vb_q[k] <= vb_q[k-1];
      end
    end
  end

  // Apply sign, saturate, and force zero for a zero vector
  vn_side_b_t         sb;
  logic [2:0][DW-1:0] res_d;
  logic               sat_d;
  logic               zero;

  assign sb   = side_b_q[DIV_STAGES-1];
  assign zero = (sb.norm == '0);

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (sb.neg[i]) begin
        res_d[i] = ~quot[i] + 1'b1;
      end else if (quot[i][DW-1]) begin
        res_d[i] = SMAX;
        sat_d    = 1'b1;
      end else begin
        res_d[i] = quot[i];
      end
      if (zero) begin
        res_d[i] = '0;
      end
    end
    if (zero) begin
      sat_d = 1'b0;
    end
  end

  // Output register
  logic [2:0][DW-1:0] res_q;
  logic [DW-1:0]      len_q;
  logic               sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      len_q <= sb.norm;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vb_q[DIV_STAGES-1];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {len_q, res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser  = sat_q;

endmodule

/* tb/tb_vector3_normalize_to_length.sv */
// Testbench for the vector normalize pipeline: random and corner vectors against a predictor.
`timescale 1ns / 100ps

module tb_vector3_normalize_to_length;
  import vn_pkg::*;

  typedef struct packed {
    logic [23:0] len;
    logic [23:0] z;
    logic [23:0] y;
    logic [23:0] x;
    logic        sat;
  } norm_word_t;

  int unsigned error_count = 0;

  // Count and print one mismatch
  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  class norm_scoreboard;
    norm_word_t pending[$];

    // Scale one component by target/norm, round half away, clamp
    function automatic logic [23:0] scale_component(longint c, longint t, longint unsigned n,
                                                    ref bit sat);
      longint unsigned p, q;
      bit neg;
      p = (c < 0 ? -c : c) * (t < 0 ? -t : t);
      q = (p + (n >> 1)) / n;
      neg = (c < 0) != (t < 0);
      if (neg) begin
        if (q > 64'h800000) begin
          sat = 1;
          return 24'h800000;
        end
        return 24'(-longint'(q));
      end
      if (q > 64'h7fffff) begin
        sat = 1;
        return 24'h7fffff;
      end
      return 24'(q);
    endfunction

    // Predict the normalized word for one accepted input
    function void note_input(logic [95:0] d);
      longint x, y, z, t;
      longint unsigned s, r, b;
      norm_word_t w;
      bit sat;
      x = longint'(signed'(d[23:0]));
      y = longint'(signed'(d[47:24]));
      z = longint'(signed'(d[71:48]));
      t = longint'(signed'(d[95:72]));
      s = x * x + y * y + z * z;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      w = '0;
      sat = 0;
      if (r != 0) begin
        w.x = scale_component(x, t, r, sat);
        w.y = scale_component(y, t, r, sat);
        w.z = scale_component(z, t, r, sat);
        w.len = r[23:0];
        w.sat = sat;
      end
      pending.push_back(w);
    endfunction

    // Compare one output word with the oldest prediction
    task check_result(logic [95:0] d, logic u);
      norm_word_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", d[23:0], 24'h0);
        return;
      end
      w = pending.pop_front();
      if (d[23:0] !== w.x) report_mismatch("out_x", d[23:0], w.x);
      if (d[47:24] !== w.y) report_mismatch("out_y", d[47:24], w.y);
      if (d[71:48] !== w.z) report_mismatch("out_z", d[71:48], w.z);
      if (d[95:72] !== w.len) report_mismatch("length", d[95:72], w.len);
      if (u !== w.sat) report_mismatch("saturated", {23'h0, u}, {23'h0, w.sat});
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  norm_scoreboard board = new();
  bit calm = 0;
  bit hold_off = 0;
  bit input_done = 0;
  int unsigned idle_cycles = 0;

  vector3_normalize_to_length dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Pick a component value, biased toward extremes and small sizes
  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'(signed'($urandom_range(0, 64)) - 32);
      3: return 24'($urandom_range(0, 1) ? 24'h010000 : 24'hff0000);
      default: return 24'($urandom());
    endcase
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(logic [95:0] d);
    while (!calm && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_input(d);
    @(negedge clk_i);
  endtask

  // Sample output words at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser[0]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // Drive the receiver ready with random stalls
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= calm || input_done || ($urandom_range(0, 99) >= 34);
  end

  // Watchdog on stalled progress
  initial begin
    wait (idle_cycles >= 3000);
    $display("TB_ERROR");
    $finish;
  end

  // Long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    wait (rst_ni);
    repeat (400) @(negedge clk_i);
    hold_off = 1;
    repeat (200) @(negedge clk_i);
    hold_off = 0;
  end

  initial begin
    logic [23:0] c [4];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // Directed: zero vector, extremes, most negative target, negative targets
    send_word('0);
    send_word({24'h010000, 72'h0});
    send_word({24'h010000, 24'h0, 24'h0, 24'h000001});
    send_word({24'h800000, 24'h0, 24'h0, 24'h000001});
    send_word({24'h800000, 24'h0, 24'h0, 24'h800000});
    send_word({24'h800000, 24'h0, 24'h0, 24'h7fffff});
    send_word({24'h7fffff, 24'h800000, 24'h800000, 24'h800000});
    send_word({24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff});
    send_word({24'hffffff, 24'h000003, 24'h000004, 24'h000000});
    send_word({24'h7fffff, 24'h000001, 24'hffffff, 24'h000001});
    send_word({24'h800000, 24'h000001, 24'h000001, 24'h000001});
    send_word({24'hff0000, 24'h030000, 24'hfc0000, 24'h050000});
    send_word({24'hffffff, 72'hffffff_ffffff_ffffff});
    // Random vectors, with a calm stretch in the middle
    for (int i = 0; i < 1540; i++) begin
      calm = (i >= 700 && i < 900);
      foreach (c[k]) c[k] = pick_value();
      send_word({c[3], c[2], c[1], c[0]});
    end
    s_axis_tvalid <= 0;
    input_done = 1;
    // Drain the pipe; the watchdog ends the run if words go missing
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/vn_pkg.sv
design/vn_sqrt.sv
design/vn_div.sv
design/vector3_normalize_to_length.sv
tb/tb_vector3_normalize_to_length.sv
